>>> hw/rtl/conductance_lif_neuron_step_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neuron step unit
// Shared forms for concurrent checks on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef CONDUCTANCE_LIF_NEURON_STEP_UNIT_MACROS_SVH
`define CONDUCTANCE_LIF_NEURON_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define CLIF_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CLIF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/clif_pkg.sv
// ----------------------------------------------------------------------------
// clif_pkg
// Types and constants of the conductance LIF neuron step unit.
// ----------------------------------------------------------------------------
package clif_pkg;

  localparam int NEURON_W = 6;
  localparam int G_W      = 23;

  localparam logic [2:0] CFG_V_REST        = 3'd0;
  localparam logic [2:0] CFG_E_EXC         = 3'd1;
  localparam logic [2:0] CFG_E_INH         = 3'd2;
  localparam logic [2:0] CFG_V_THRESHOLD   = 3'd3;
  localparam logic [2:0] CFG_V_RESET       = 3'd4;
  localparam logic [2:0] CFG_SYN_DECAY     = 3'd5;
  localparam logic [2:0] CFG_MEMBRANE_RATE = 3'd6;
  localparam logic [2:0] CFG_EXC_SCALE     = 3'd7;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_EXC  = 2'd1;
  localparam logic [1:0] KIND_INH  = 2'd2;

  localparam logic [15:0] MEMBRANE_INIT = 16'hC400;
  localparam logic [4:0]  COUNT_MAX     = 5'd31;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_READ,
    ST_WR_WRITE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [15:0] v_rest;
    logic [15:0] e_exc;
    logic [15:0] e_inh;
    logic [15:0] v_threshold;
    logic [15:0] v_reset;
    logic [15:0] syn_decay;
    logic [15:0] membrane_rate;
    logic [15:0] exc_scale;
  } cfg_t;

  typedef struct packed {
    logic [15:0] weight;
    logic [1:0]  kind;
    logic [15:0] exc;
    logic [15:0] inh;
  } syn_word_t;

  localparam int SYN_W = $bits(syn_word_t);

  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic                fired;
    logic [NEURON_W-1:0] neuron;
  } syn_issue_t;

  typedef struct packed {
    logic                valid;
    logic [NEURON_W-1:0] neuron;
    logic [G_W-1:0]      ge;
    logic [G_W-1:0]      gi;
  } group_t;

  typedef struct packed {
    logic                valid;
    logic                fire;
    logic [NEURON_W-1:0] neuron;
  } fire_t;

endpackage

>>> hw/rtl/clif_ram.sv
// ----------------------------------------------------------------------------
// clif_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module clif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/clif_syn_unit.sv
// ----------------------------------------------------------------------------
// clif_syn_unit
// Synapse trace update and per-neuron conductance accumulation.
// ----------------------------------------------------------------------------
module clif_syn_unit #(
  parameter int ADDR_W = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  clif_pkg::cfg_t                  cfg,
  input  clif_pkg::syn_issue_t            issue,
  input  logic [ADDR_W-1:0]               issue_addr,
  input  clif_pkg::syn_word_t             rdata,
  output logic                            we,
  output logic [ADDR_W-1:0]               waddr,
  output clif_pkg::syn_word_t             wdata,
  output clif_pkg::group_t                group,
  output logic                            mem_re,
  output logic [clif_pkg::NEURON_W-1:0]   mem_raddr,
  output logic                            clip,
  output logic                            active
);

  clif_pkg::syn_issue_t       s1;
  logic [ADDR_W-1:0]          s1_addr;
  logic [clif_pkg::G_W-1:0]   ge_acc;
  logic [clif_pkg::G_W-1:0]   gi_acc;

  logic                       is_exc;
  logic                       is_inh;
  logic [15:0]                sel;
  logic [31:0]                decay_prod;
  logic [31:0]                scale_prod;
  logic [23:0]                inc;
  logic [24:0]                sum;
  logic                       over;
  logic [15:0]                upd;
  logic [clif_pkg::G_W-1:0]   ge_sum;
  logic [clif_pkg::G_W-1:0]   gi_sum;

  always_comb begin
    is_exc     = rdata.kind == clif_pkg::KIND_EXC;
    is_inh     = rdata.kind == clif_pkg::KIND_INH;
    sel        = is_inh ? rdata.inh : rdata.exc;
    decay_prod = 32'(sel) * 32'(cfg.syn_decay);
    scale_prod = 32'(rdata.weight) * 32'(cfg.exc_scale);
    inc        = is_inh ? {8'd0, rdata.weight} : scale_prod[31:8];
    sum        = {9'd0, decay_prod[31:16]} + {1'b0, inc};
    over       = s1.fired && (sum > 25'd65535);
    if (over) begin
      upd = 16'hFFFF;
    end else if (s1.fired) begin
      upd = sum[15:0];
    end else begin
      upd = decay_prod[31:16];
    end
    wdata = rdata;
    if (is_exc) begin
      wdata.exc = upd;
    end
    if (is_inh) begin
      wdata.inh = upd;
    end
    we        = s1.valid && (is_exc || is_inh);
    waddr     = s1_addr;
    clip      = we && over;
    ge_sum    = (s1.first ? '0 : ge_acc) + (is_exc ? {7'd0, upd} : '0);
    gi_sum    = (s1.first ? '0 : gi_acc) + (is_inh ? {7'd0, upd} : '0);
    mem_re    = s1.valid && s1.last;
    mem_raddr = s1.neuron;
    active    = s1.valid || group.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1          <= '0;
      group.valid <= 1'b0;
    end else begin
      s1          <= issue;
      group.valid <= s1.valid && s1.last;
    end
    s1_addr <= issue_addr;
    if (s1.valid) begin
      ge_acc <= ge_sum;
      gi_acc <= gi_sum;
    end
    group.neuron <= s1.neuron;
    group.ge     <= ge_sum;
    group.gi     <= gi_sum;
  end

endmodule

>>> hw/rtl/clif_mem_unit.sv
// ----------------------------------------------------------------------------
// clif_mem_unit
// Membrane store and three-stage membrane update with fire check.
// ----------------------------------------------------------------------------
module clif_mem_unit #(
  parameter int NEURONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  clif_pkg::cfg_t                cfg,
  input  logic                          clr_we,
  input  logic [clif_pkg::NEURON_W-1:0] clr_addr,
  input  logic [clif_pkg::NEURON_W-1:0] rd_addr,
  input  clif_pkg::group_t              group,
  output clif_pkg::fire_t               fire,
  output logic                          active
);

  localparam int MAW = NEURONS > 1 ? $clog2(NEURONS) : 1;

  logic [15:0]                  v;
  logic signed [16:0]           dr;
  logic signed [16:0]           de;
  logic signed [16:0]           di;
  logic signed [40:0]           pr;
  logic signed [40:0]           pe;
  logic signed [40:0]           pi;

  logic                         m1_valid;
  logic [clif_pkg::NEURON_W-1:0] m1_n;
  logic [15:0]                  m1_v;
  logic signed [40:0]           m1_pr;
  logic signed [40:0]           m1_pe;
  logic signed [40:0]           m1_pi;
  logic signed [42:0]           drive;

  logic                         m2_valid;
  logic [clif_pkg::NEURON_W-1:0] m2_n;
  logic [15:0]                  m2_v;
  logic signed [42:0]           m2_drive;
  logic signed [59:0]           prod;
  logic signed [36:0]           nv;
  logic [15:0]                  newv;
  logic                         fired;

  logic                         ram_we;
  logic [MAW-1:0]               ram_waddr;
  logic [15:0]                  ram_wdata;

  clif_ram #(
    .WIDTH (16),
    .DEPTH (NEURONS)
  ) u_membrane (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (MAW'(rd_addr)),
    .rdata (v)
  );

  always_comb begin
    dr = $signed({cfg.v_rest[15], cfg.v_rest}) - $signed({v[15], v});
    de = $signed({cfg.e_exc[15], cfg.e_exc}) - $signed({v[15], v});
    di = $signed({cfg.e_inh[15], cfg.e_inh}) - $signed({v[15], v});
    pr = $signed({{16{dr[16]}}, dr, 8'd0});
    pe = $signed({1'b0, group.ge}) * de;
    pi = $signed({1'b0, group.gi}) * di;
  end

  always_comb begin
    drive = $signed({{2{m1_pr[40]}}, m1_pr}) + $signed({{2{m1_pe[40]}}, m1_pe})
          + $signed({{2{m1_pi[40]}}, m1_pi});
  end

  always_comb begin
    prod = m2_drive * $signed({1'b0, cfg.membrane_rate}) + $signed(60'd8388608);
    nv   = $signed({{21{m2_v[15]}}, m2_v}) + $signed({prod[59], prod[59:24]});
    if (nv > 37'sd32767) begin
      newv = 16'h7FFF;
    end else if (nv < -37'sd32768) begin
      newv = 16'h8000;
    end else begin
      newv = nv[15:0];
    end
    fired       = $signed(newv) >= $signed(cfg.v_threshold);
    fire.valid  = m2_valid;
    fire.fire   = fired;
    fire.neuron = m2_n;
    if (clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = MAW'(clr_addr);
      ram_wdata = clif_pkg::MEMBRANE_INIT;
    end else begin
      ram_we    = m2_valid;
      ram_waddr = MAW'(m2_n);
      ram_wdata = fired ? cfg.v_reset : newv;
    end
    active = m1_valid || m2_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m1_valid <= group.valid;
      m2_valid <= m1_valid;
    end
    m1_n     <= group.neuron;
    m1_v     <= v;
    m1_pr    <= pr;
    m1_pe    <= pe;
    m1_pi    <= pi;
    m2_n     <= m1_n;
    m2_v     <= m1_v;
    m2_drive <= drive;
  end

endmodule

>>> hw/rtl/conductance_lif_neuron_step_unit.sv
// ----------------------------------------------------------------------------
// conductance_lif_neuron_step_unit
// Synapse write: the word is read in ST_WR_READ and written back in
//   ST_WR_WRITE; done rises as the unit returns to idle.
// Time step: ST_SCAN issues one synapse entry per cycle, then ST_DRAIN waits
//   for the synapse and membrane pipelines to empty; done rises as the unit
//   returns to idle, and a new start is taken only once the unit is idle.
//   The receiver cannot stall results. Reset: busy for a clearing pass over
//   the synapse memory; membranes load MEMBRANE_INIT, the reset value of v_reset.
// ----------------------------------------------------------------------------
`include "conductance_lif_neuron_step_unit_macros.svh"

module conductance_lif_neuron_step_unit #(
  parameter int NEURONS = 16,
  parameter int INPUTS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [3:0]  neuron_index,
  input  logic [4:0]  input_index,
  input  logic [15:0] weight_value,
  input  logic [1:0]  conn_type,
  input  logic [31:0] pre_spikes,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] post_spikes,
  output logic [4:0]  spike_count,
  output logic        trace_saturated
);

  localparam int SYN = NEURONS * INPUTS;
  localparam int SAW = SYN > 1 ? $clog2(SYN) : 1;
  localparam int NW  = NEURONS > 1 ? $clog2(NEURONS) : 1;
  localparam int IW  = INPUTS > 1 ? $clog2(INPUTS) : 1;

  clif_pkg::state_t      state;
  clif_pkg::state_t      state_next;
  clif_pkg::cfg_t        cfg;

  logic [SAW-1:0]        clr_addr;
  logic [SAW-1:0]        scan_addr;
  logic [NW-1:0]         scan_n;
  logic [IW-1:0]         scan_j;
  logic [SAW-1:0]        wr_addr;
  logic [15:0]           wr_weight;
  logic [1:0]            wr_kind;
  logic                  wr_ok;
  logic [31:0]           pre_reg;
  logic [15:0]           spk;
  logic [4:0]            cnt;
  logic                  sat;

  logic                  accept;
  logic                  scan_last_j;
  logic                  scan_last;
  logic                  pipe_active;
  logic [15:0]           wr_lin;
  logic [5:0]            j6;

  logic                  syn_we;
  logic [SAW-1:0]        syn_waddr;
  clif_pkg::syn_word_t   syn_wdata;
  logic [SAW-1:0]        syn_raddr;
  clif_pkg::syn_word_t   syn_rdata;

  clif_pkg::syn_issue_t  issue;
  logic                  unit_we;
  logic [SAW-1:0]        unit_waddr;
  clif_pkg::syn_word_t   unit_wdata;
  clif_pkg::group_t      group;
  logic                  mem_re;
  logic [clif_pkg::NEURON_W-1:0] mem_raddr;
  logic                  clip;
  logic                  syn_active;
  logic                  mem_clr_we;
  clif_pkg::fire_t       fire;
  logic                  mem_active;

  clif_ram #(
    .WIDTH (clif_pkg::SYN_W),
    .DEPTH (SYN)
  ) u_synapse (
    .clk   (clk),
    .we    (syn_we),
    .waddr (syn_waddr),
    .wdata (syn_wdata),
    .raddr (syn_raddr),
    .rdata (syn_rdata)
  );

  clif_syn_unit #(
    .ADDR_W (SAW)
  ) u_syn (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .issue      (issue),
    .issue_addr (scan_addr),
    .rdata      (syn_rdata),
    .we         (unit_we),
    .waddr      (unit_waddr),
    .wdata      (unit_wdata),
    .group      (group),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .clip       (clip),
    .active     (syn_active)
  );

  clif_mem_unit #(
    .NEURONS (NEURONS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clr_we   (mem_clr_we),
    .clr_addr (clif_pkg::NEURON_W'(clr_addr)),
    .rd_addr  (mem_re ? mem_raddr : '0),
    .group    (group),
    .fire     (fire),
    .active   (mem_active)
  );

  always_comb begin
    busy        = state != clif_pkg::ST_IDLE;
    accept      = start && !busy;
    scan_last_j = scan_j == IW'(INPUTS - 1);
    scan_last   = scan_last_j && (scan_n == NW'(NEURONS - 1));
    pipe_active = syn_active || mem_active;
    wr_lin      = 16'(neuron_index) * 16'(INPUTS) + 16'(input_index);
    j6          = 6'(scan_j);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      clif_pkg::ST_CLEAR: begin
        if (clr_addr == SAW'(SYN - 1)) begin
          state_next = clif_pkg::ST_IDLE;
        end
      end
      clif_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = mode ? clif_pkg::ST_SCAN : clif_pkg::ST_WR_READ;
        end
      end
      clif_pkg::ST_WR_READ:  state_next = clif_pkg::ST_WR_WRITE;
      clif_pkg::ST_WR_WRITE: state_next = clif_pkg::ST_IDLE;
      clif_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = clif_pkg::ST_DRAIN;
        end
      end
      clif_pkg::ST_DRAIN: begin
        if (!pipe_active) begin
          state_next = clif_pkg::ST_IDLE;
        end
      end
      default: state_next = clif_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    syn_raddr  = scan_addr;
    syn_we     = unit_we;
    syn_waddr  = unit_waddr;
    syn_wdata  = unit_wdata;
    issue      = '0;
    mem_clr_we = 1'b0;
    unique case (state)
      clif_pkg::ST_CLEAR: begin
        syn_we     = 1'b1;
        syn_waddr  = clr_addr;
        syn_wdata  = '0;
        mem_clr_we = {1'b0, clr_addr} < (SAW + 1)'(NEURONS);
      end
      clif_pkg::ST_WR_READ: begin
        syn_raddr = wr_addr;
      end
      clif_pkg::ST_WR_WRITE: begin
        syn_we           = wr_ok;
        syn_waddr        = wr_addr;
        syn_wdata        = syn_rdata;
        syn_wdata.weight = wr_weight;
        syn_wdata.kind   = wr_kind;
      end
      clif_pkg::ST_SCAN: begin
        issue.valid  = 1'b1;
        issue.first  = scan_j == '0;
        issue.last   = scan_last_j;
        issue.fired  = !j6[5] && pre_reg[j6[4:0]];
        issue.neuron = clif_pkg::NEURON_W'(scan_n);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= clif_pkg::ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      cfg.v_rest        <= 16'hBA00;
      cfg.e_exc         <= 16'h0000;
      cfg.e_inh         <= 16'hB000;
      cfg.v_threshold   <= 16'hCA00;
      cfg.v_reset       <= 16'hC400;
      cfg.syn_decay     <= 16'd62259;
      cfg.membrane_rate <= 16'd3277;
      cfg.exc_scale     <= 16'd256;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == clif_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          clif_pkg::CFG_V_REST:        cfg.v_rest        <= cfg_data;
          clif_pkg::CFG_E_EXC:         cfg.e_exc         <= cfg_data;
          clif_pkg::CFG_E_INH:         cfg.e_inh         <= cfg_data;
          clif_pkg::CFG_V_THRESHOLD:   cfg.v_threshold   <= cfg_data;
          clif_pkg::CFG_V_RESET:       cfg.v_reset       <= cfg_data;
          clif_pkg::CFG_SYN_DECAY:     cfg.syn_decay     <= cfg_data;
          clif_pkg::CFG_MEMBRANE_RATE: cfg.membrane_rate <= cfg_data;
          clif_pkg::CFG_EXC_SCALE:     cfg.exc_scale     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == clif_pkg::ST_WR_WRITE) begin
        done <= 1'b1;
      end
      if (state == clif_pkg::ST_DRAIN && !pipe_active) begin
        done <= 1'b1;
      end
    end

    if (accept) begin
      wr_addr   <= wr_lin[SAW-1:0];
      wr_ok     <= (32'(neuron_index) < 32'(NEURONS)) && (32'(input_index) < 32'(INPUTS));
      wr_weight <= weight_value;
      wr_kind   <= conn_type;
      pre_reg   <= pre_spikes;
      scan_addr <= '0;
      scan_n    <= '0;
      scan_j    <= '0;
      spk       <= '0;
      cnt       <= '0;
      sat       <= 1'b0;
    end else begin
      if (state == clif_pkg::ST_SCAN) begin
        scan_addr <= scan_addr + 1'b1;
        if (scan_last_j) begin
          scan_j <= '0;
          scan_n <= scan_n + 1'b1;
        end else begin
          scan_j <= scan_j + 1'b1;
        end
      end
      if (clip) begin
        sat <= 1'b1;
      end
      if (fire.valid && fire.fire) begin
        if (!fire.neuron[5] && !fire.neuron[4]) begin
          spk <= spk | (16'd1 << fire.neuron[3:0]);
        end
        if (cnt != clif_pkg::COUNT_MAX) begin
          cnt <= cnt + 1'b1;
        end
      end
    end

    if (state == clif_pkg::ST_WR_WRITE) begin
      post_spikes     <= '0;
      spike_count     <= '0;
      trace_saturated <= 1'b0;
    end else if (state == clif_pkg::ST_DRAIN) begin
      post_spikes     <= spk;
      spike_count     <= cnt;
      trace_saturated <= sat;
    end
  end

  `CLIF_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `CLIF_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CLIF_ASSERT_IMPLY(a_count_spikes, clk, rst, done && post_spikes != 16'd0, spike_count != 5'd0)
  `CLIF_ASSERT_IMPLY(a_idle_no_write, clk, rst, state == clif_pkg::ST_IDLE, !syn_we)

endmodule

>>> tb/lif_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lif_step_checker
// Watches the command, register and result ports of the neuron step unit,
// predicts each result from its own network model and compares field by field.
// ----------------------------------------------------------------------------
module lif_step_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [3:0]  neuron_index,
  input  logic [4:0]  input_index,
  input  logic [15:0] weight_value,
  input  logic [1:0]  conn_type,
  input  logic [31:0] pre_spikes,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        done,
  input  logic [15:0] post_spikes,
  input  logic [4:0]  spike_count,
  input  logic        trace_saturated,
  output int          fail_count,
  output int          pending
);

  localparam int NN = 16;
  localparam int NI = 32;

  typedef struct packed {
    logic [15:0] spikes;
    logic [4:0]  count;
    logic        sat;
  } step_out_t;

  step_out_t      step_q[$];
  clif_pkg::cfg_t regs;
  logic [15:0]    wt[NN*NI];
  logic [1:0]     kd[NN*NI];
  logic [15:0]    te[NN*NI];
  logic [15:0]    ti[NN*NI];
  logic signed [15:0] vm[NN];

  function automatic logic [15:0] decay_add(input logic [15:0] t, input logic fired,
                                            input logic [31:0] inc, inout logic sat);
    logic [31:0] v;
    v = (32'(t) * 32'(regs.syn_decay)) >> 16;
    if (fired) begin
      v = v + inc;
      if (v > 32'hFFFF) begin
        v = 32'hFFFF;
        sat = 1'b1;
      end
    end
    return v[15:0];
  endfunction

  function automatic step_out_t advance(input logic [31:0] pre);
    step_out_t r;
    longint ge, gi, v, d, x, dv;
    int a;
    r = '0;
    for (int i = 0; i < NN; i++) begin
      ge = 0;
      gi = 0;
      for (int j = 0; j < NI; j++) begin
        a = i * NI + j;
        if (kd[a] == clif_pkg::KIND_EXC) begin
          te[a] = decay_add(te[a], pre[j],
                            (32'(wt[a]) * 32'(regs.exc_scale)) >> 8, r.sat);
          ge += te[a];
        end else if (kd[a] == clif_pkg::KIND_INH) begin
          ti[a] = decay_add(ti[a], pre[j], 32'(wt[a]), r.sat);
          gi += ti[a];
        end
      end
      v = vm[i];
      d = 256 * (longint'($signed(regs.v_rest)) - v)
        + ge * (longint'($signed(regs.e_exc)) - v)
        + gi * (longint'($signed(regs.e_inh)) - v);
      x = d * longint'(regs.membrane_rate) + (64'sd1 <<< 23);
      dv = x >>> 24;
      v = v + dv;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      vm[i] = v[15:0];
    end
    for (int i = 0; i < NN; i++) begin
      if (vm[i] >= $signed(regs.v_threshold)) begin
        vm[i] = regs.v_reset;
        r.spikes[i] = 1'b1;
        r.count++;
      end
    end
    return r;
  endfunction

  assign pending = step_q.size();

  always @(posedge clk) begin
    step_out_t e;
    int errs;
    errs = 0;
    if (rst) begin
      regs <= '{16'hBA00, 16'h0000, 16'hB000, 16'hCA00, 16'hC400,
                16'd62259, 16'd3277, 16'd256};
      for (int k = 0; k < NN*NI; k++) begin
        wt[k] = '0; kd[k] = '0; te[k] = '0; ti[k] = '0;
      end
      for (int k = 0; k < NN; k++) vm[k] = clif_pkg::MEMBRANE_INIT;
      step_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          clif_pkg::CFG_V_REST:        regs.v_rest        <= cfg_data;
          clif_pkg::CFG_E_EXC:         regs.e_exc         <= cfg_data;
          clif_pkg::CFG_E_INH:         regs.e_inh         <= cfg_data;
          clif_pkg::CFG_V_THRESHOLD:   regs.v_threshold   <= cfg_data;
          clif_pkg::CFG_V_RESET:       regs.v_reset       <= cfg_data;
          clif_pkg::CFG_SYN_DECAY:     regs.syn_decay     <= cfg_data;
          clif_pkg::CFG_MEMBRANE_RATE: regs.membrane_rate <= cfg_data;
          clif_pkg::CFG_EXC_SCALE:     regs.exc_scale     <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!mode) begin
          wt[{neuron_index, input_index}] = weight_value;
          kd[{neuron_index, input_index}] = conn_type;
          step_q.push_back('0);
        end else begin
          step_q.push_back(advance(pre_spikes));
        end
      end
      if (done) begin
        if (step_q.size() == 0) begin
          $error("result with no transfer waiting");
          errs++;
        end else begin
          e = step_q.pop_front();
          if (e.spikes !== post_spikes) begin
            $error("post_spikes expected %h actual %h", e.spikes, post_spikes);
            errs++;
          end
          if (e.count !== spike_count) begin
            $error("spike_count expected %0d actual %0d", e.count, spike_count);
            errs++;
          end
          if (e.sat !== trace_saturated) begin
            $error("trace_saturated expected %0d actual %0d", e.sat, trace_saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives synapse writes, time steps and register settings into the neuron
// step unit; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [3:0]  neuron_index = '0;
  logic [4:0]  input_index = '0;
  logic [15:0] weight_value = '0;
  logic [1:0]  conn_type = '0;
  logic [31:0] pre_spikes = '0;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic [15:0] post_spikes;
  logic [4:0]  spike_count;
  logic        trace_saturated;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int          write_items = 0;
  int          step_items = 0;
  bit          gaps_on = 1'b1;

  always #2 clk = ~clk;

  conductance_lif_neuron_step_unit dut (.*);

  lif_step_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // start stays high after a transfer; drop it on a gap or in settle
  task automatic transfer(input logic m, input logic [3:0] n, input logic [4:0] k,
                          input logic [15:0] w, input logic [1:0] c,
                          input logic [31:0] p);
    while (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= m;
    neuron_index <= n;
    input_index  <= k;
    weight_value <= w;
    conn_type    <= c;
    pre_spikes   <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m) step_items++;
    else write_items++;
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic wire_up(input int count);
    repeat (count)
      transfer(1'b0, 4'($urandom), 5'($urandom),
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023)),
               2'($urandom_range(3)), $urandom);
  endtask

  task automatic run_steps(input int count, input int density);
    logic [31:0] p;
    repeat (count) begin
      p = '0;
      for (int j = 0; j < 32; j++) if ($urandom_range(99) < density) p[j] = 1'b1;
      transfer(1'b1, 4'($urandom), 5'($urandom), 16'($urandom), 2'($urandom), p);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    transfer(1'b1, '0, '0, '0, clif_pkg::KIND_NONE, '0);
    transfer(1'b0, 4'd0, 5'd0, 16'hFFFF, clif_pkg::KIND_EXC, '0);
    transfer(1'b0, 4'd15, 5'd31, 16'hFFFF, clif_pkg::KIND_INH, '0);
    transfer(1'b0, 4'd3, 5'd7, 16'h0000, 2'd3, '0);
    transfer(1'b0, 4'd5, 5'd1, 16'h0800, clif_pkg::KIND_EXC, '0);
    transfer(1'b1, '0, '0, '0, clif_pkg::KIND_NONE, 32'hFFFF_FFFF);
    transfer(1'b1, '0, '0, '0, clif_pkg::KIND_NONE, 32'hFFFF_FFFF);
    transfer(1'b0, 4'd5, 5'd1, 16'h0800, clif_pkg::KIND_INH, '0);
    transfer(1'b1, '0, '0, '0, clif_pkg::KIND_NONE, 32'h0000_0002);
    transfer(1'b0, 4'd5, 5'd1, 16'h0800, clif_pkg::KIND_EXC, '0);
    transfer(1'b1, '0, '0, '0, clif_pkg::KIND_NONE, 32'h8000_0001);
    transfer(1'b0, 4'd5, 5'd1, 16'h0800, clif_pkg::KIND_NONE, '0);
    transfer(1'b1, '0, '0, '0, clif_pkg::KIND_NONE, 32'hAAAA_5555);
    settle();

    set_reg(clif_pkg::CFG_SYN_DECAY, 16'hFFFF);
    set_reg(clif_pkg::CFG_EXC_SCALE, 16'hFFFF);
    set_reg(clif_pkg::CFG_MEMBRANE_RATE, 16'hFFFF);
    set_reg(clif_pkg::CFG_V_THRESHOLD, 16'h8000);
    set_reg(clif_pkg::CFG_V_RESET, 16'h7FFF);
    set_reg(clif_pkg::CFG_E_EXC, 16'h7FFF);
    set_reg(clif_pkg::CFG_E_INH, 16'h8000);
    set_reg(clif_pkg::CFG_V_REST, 16'h7FFF);
    wire_up(60);
    run_steps(20, 50);
    settle();

    set_reg(clif_pkg::CFG_SYN_DECAY, 16'h0000);
    set_reg(clif_pkg::CFG_EXC_SCALE, 16'h0000);
    set_reg(clif_pkg::CFG_MEMBRANE_RATE, 16'h0000);
    set_reg(clif_pkg::CFG_V_THRESHOLD, 16'h7FFF);
    set_reg(clif_pkg::CFG_V_REST, 16'h8000);
    set_reg(clif_pkg::CFG_E_EXC, 16'h8000);
    set_reg(clif_pkg::CFG_E_INH, 16'h7FFF);
    set_reg(clif_pkg::CFG_V_RESET, 16'h8000);
    run_steps(10, 50);
    settle();

    gaps_on = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(clif_pkg::CFG_V_REST, 16'hBA00 + 16'($urandom_range(2047)));
      set_reg(clif_pkg::CFG_E_EXC, $urandom_range(1) ? 16'h0000 : 16'($urandom));
      set_reg(clif_pkg::CFG_E_INH, 16'hB000);
      set_reg(clif_pkg::CFG_V_THRESHOLD, 16'hC800 + 16'($urandom_range(2047)));
      set_reg(clif_pkg::CFG_V_RESET, 16'hC400);
      set_reg(clif_pkg::CFG_SYN_DECAY, 16'($urandom_range(65535, 50000)));
      set_reg(clif_pkg::CFG_MEMBRANE_RATE, 16'($urandom_range(12000, 1000)));
      set_reg(clif_pkg::CFG_EXC_SCALE, 16'($urandom_range(2048, 64)));
      wire_up(80);
      run_steps(30, $urandom_range(70, 5));
      settle();
      gaps_on = (ph != 3);
    end

    settle();
    $display("Ran %0d synapse writes and %0d time steps under reset, extreme and",
             write_items, step_items);
    $display("eight random register settings, with and without idle gaps.");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
